// ----- rtl/assert_macros.svh -----
// Assertion macros used by the histogram counter back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define PHC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define PHC_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/phc_pkg.sv -----
// Shared types, codes and constants of the packet ID histogram counter
`default_nettype none
package phc_pkg;

	localparam int ID_W    = 32;
	localparam int CLS_W   = 3;
	localparam int RADDR_W = 12;
	localparam int CNT_W   = 32;
	localparam int UNK_N   = 7;
	localparam int UNK_W   = 3;
	localparam int TBL_AW  = 15;
	localparam int OP_W    = 3;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	localparam int PI_ENTRIES_DEF  = 768;
	localparam int X1_ENTRIES_DEF  = 256;
	localparam int VDC_ENTRIES_DEF = 256;
	localparam int MRP_ENTRIES_DEF = 1536;
	localparam int IPC_ENTRIES_DEF = 256;

	localparam logic [ID_W-1:0] IPC_ID_BASE = 32'd600;

	localparam logic [CLS_W-1:0] CLS_PI  = 3'd0;
	localparam logic [CLS_W-1:0] CLS_X1  = 3'd1;
	localparam logic [CLS_W-1:0] CLS_VDC = 3'd2;
	localparam logic [CLS_W-1:0] CLS_BF  = 3'd3;
	localparam logic [CLS_W-1:0] CLS_MRP = 3'd4;
	localparam logic [CLS_W-1:0] CLS_IPC = 3'd5;
	localparam logic [CLS_W-1:0] CLS_UNK_LO = 3'd6;
	localparam logic [CLS_W-1:0] CLS_UNK_HI = 3'd7;

	localparam logic [UNK_W-1:0] UNK_TYPE_SLOT = 3'd6;

	localparam logic KIND_COUNT = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	localparam logic [OP_W-1:0] OP_CNT_TBL = 3'd0;
	localparam logic [OP_W-1:0] OP_CNT_UNK = 3'd1;
	localparam logic [OP_W-1:0] OP_RD_TBL  = 3'd2;
	localparam logic [OP_W-1:0] OP_RD_UNK  = 3'd3;
	localparam logic [OP_W-1:0] OP_RD_NONE = 3'd4;

	typedef struct packed {
		logic               kind;
		logic [CLS_W-1:0]   packet_class;
		logic [ID_W-1:0]    packet_id;
		logic [RADDR_W-1:0] read_address;
	} in_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] counter_value;
		logic             in_table;
	} out_item_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [TBL_AW-1:0] tbl_addr;
		logic [UNK_W-1:0]  unk_idx;
	} cmd_t;

endpackage
`default_nettype wire

// ----- rtl/packet_id_histogram_counter.sv -----
// Top level of the packet ID histogram counter: classifier, queue, counter back end.
// Path: queue entry, stage 1 with the store read, result register. Throughput: one
// item per cycle when not clearing and the result is not stalled; the store
// read-modify-write forwards the last write. Reset: inputs queued but not served;
// counters cleared, 2*PI+X1+VDC+MRP+IPC (3840 by default) entries swept one a cycle.
`default_nettype none
module packet_id_histogram_counter #(
	parameter int PI_ENTRIES  = phc_pkg::PI_ENTRIES_DEF,
	parameter int X1_ENTRIES  = phc_pkg::X1_ENTRIES_DEF,
	parameter int VDC_ENTRIES = phc_pkg::VDC_ENTRIES_DEF,
	parameter int MRP_ENTRIES = phc_pkg::MRP_ENTRIES_DEF,
	parameter int IPC_ENTRIES = phc_pkg::IPC_ENTRIES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire phc_pkg::in_item_t  in_data,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      phc_pkg::out_item_t out_data
);
	import phc_pkg::*;

	localparam int TBL_DEPTH = 2 * PI_ENTRIES + X1_ENTRIES + VDC_ENTRIES
		+ MRP_ENTRIES + IPC_ENTRIES;

	cmd_t front_cmd;
	cmd_t q_head;
	logic q_full;
	logic q_not_empty;
	logic q_pop;

	phc_front #(
		.PI_ENTRIES (PI_ENTRIES),
		.X1_ENTRIES (X1_ENTRIES),
		.VDC_ENTRIES(VDC_ENTRIES),
		.MRP_ENTRIES(MRP_ENTRIES),
		.IPC_ENTRIES(IPC_ENTRIES)
	) u_front (
		.item(in_data),
		.cmd (front_cmd)
	);

	phc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid),
		.push_cmd (front_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.head     (q_head)
	);

	assign in_ready = !q_full;

	phc_back #(
		.TBL_DEPTH(TBL_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_not_empty(q_not_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
`default_nettype wire

// ----- rtl/phc_ram.sv -----
// Generic single-write, single-read RAM with registered read-first output
`default_nettype none
module phc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 3840
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/phc_front.sv -----
// Front end: classify an input item into a counter operation
`default_nettype none
module phc_front #(
	parameter int PI_ENTRIES  = phc_pkg::PI_ENTRIES_DEF,
	parameter int X1_ENTRIES  = phc_pkg::X1_ENTRIES_DEF,
	parameter int VDC_ENTRIES = phc_pkg::VDC_ENTRIES_DEF,
	parameter int MRP_ENTRIES = phc_pkg::MRP_ENTRIES_DEF,
	parameter int IPC_ENTRIES = phc_pkg::IPC_ENTRIES_DEF
) (
	input  wire phc_pkg::in_item_t item,
	output      phc_pkg::cmd_t     cmd
);
	import phc_pkg::*;

	localparam int BASE_PI  = 0;
	localparam int BASE_X1  = PI_ENTRIES;
	localparam int BASE_VDC = BASE_X1 + X1_ENTRIES;
	localparam int BASE_BF  = BASE_VDC + VDC_ENTRIES;
	localparam int BASE_MRP = BASE_BF + PI_ENTRIES;
	localparam int BASE_IPC = BASE_MRP + MRP_ENTRIES;
	localparam int TBL_DEPTH = BASE_IPC + IPC_ENTRIES;

	logic [TBL_AW-1:0] base;
	logic [ID_W-1:0]   size;
	logic [ID_W-1:0]   off;
	logic              id_ok;
	logic [ID_W-1:0]   rd_ext;
	logic [ID_W-1:0]   rd_unk_off;

	always_comb begin
		case (item.packet_class)
			CLS_PI: begin
				base = TBL_AW'(BASE_PI);
				size = ID_W'(PI_ENTRIES);
			end
			CLS_X1: begin
				base = TBL_AW'(BASE_X1);
				size = ID_W'(X1_ENTRIES);
			end
			CLS_VDC: begin
				base = TBL_AW'(BASE_VDC);
				size = ID_W'(VDC_ENTRIES);
			end
			CLS_BF: begin
				base = TBL_AW'(BASE_BF);
				size = ID_W'(PI_ENTRIES);
			end
			CLS_MRP: begin
				base = TBL_AW'(BASE_MRP);
				size = ID_W'(MRP_ENTRIES);
			end
			CLS_IPC: begin
				base = TBL_AW'(BASE_IPC);
				size = ID_W'(IPC_ENTRIES);
			end
			default: begin
				base = '0;
				size = '0;
			end
		endcase
	end

	always_comb begin
		if (item.packet_class == CLS_IPC) begin
			off   = item.packet_id - IPC_ID_BASE;
			id_ok = (item.packet_id >= IPC_ID_BASE) && (off < size);
		end else begin
			off   = item.packet_id;
			id_ok = off < size;
		end
	end

	assign rd_ext     = ID_W'(item.read_address);
	assign rd_unk_off = rd_ext - ID_W'(TBL_DEPTH);

	always_comb begin
		cmd.op       = OP_RD_NONE;
		cmd.tbl_addr = TBL_AW'(item.read_address);
		cmd.unk_idx  = rd_unk_off[UNK_W-1:0];
		if (item.kind == KIND_READ) begin
			if (rd_ext < ID_W'(TBL_DEPTH)) begin
				cmd.op = OP_RD_TBL;
			end else if (rd_unk_off < ID_W'(UNK_N)) begin
				cmd.op = OP_RD_UNK;
			end
		end else if (item.packet_class inside {[CLS_UNK_LO:CLS_UNK_HI]}) begin
			cmd.op      = OP_CNT_UNK;
			cmd.unk_idx = UNK_TYPE_SLOT;
		end else if (id_ok) begin
			cmd.op       = OP_CNT_TBL;
			cmd.tbl_addr = base + off[TBL_AW-1:0];
		end else begin
			cmd.op      = OP_CNT_UNK;
			cmd.unk_idx = item.packet_class;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/phc_queue.sv -----
// Short command queue between the front and back ends
`default_nettype none
module phc_queue (
	input  wire  logic          clk,
	input  wire  logic          arst_n,
	input  wire  logic          push,
	input  wire  phc_pkg::cmd_t push_cmd,
	output       logic          full,
	input  wire  logic          pop,
	output       logic          not_empty,
	output       phc_pkg::cmd_t head
);
	import phc_pkg::*;

	cmd_t              ent_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_AW:0]     cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full      = cnt_q == (Q_AW+1)'(Q_DEPTH);
	assign not_empty = cnt_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/phc_back.sv -----
// Back end: counter store read-modify-write, unknown counters, result register
`default_nettype none
`include "assert_macros.svh"
module phc_back #(
	parameter int TBL_DEPTH = 3840
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_not_empty,
	input  wire phc_pkg::cmd_t      q_head,
	output      logic               q_pop,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      phc_pkg::out_item_t out_data
);
	import phc_pkg::*;

	localparam int AW = $clog2(TBL_DEPTH);

	logic              clr_q;
	logic [AW-1:0]     clr_addr_q;
	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [AW-1:0]     addr_s1;
	logic              adv;
	logic              lw_valid_q;
	logic [AW-1:0]     lw_addr_q;
	logic [CNT_W-1:0]  lw_data_q;
	logic [CNT_W-1:0]  unk_q [UNK_N];
	logic [CNT_W-1:0]  rdata;
	logic [CNT_W-1:0]  tbl_val;
	logic [CNT_W-1:0]  tbl_inc;
	logic [CNT_W-1:0]  unk_val;
	logic [CNT_W-1:0]  unk_inc;
	logic              cnt_tbl_wr;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CNT_W-1:0]  ram_wdata;
	out_item_t         res;
	logic              out_valid_q;
	out_item_t         out_q;

	assign adv        = valid_s1 && (!out_valid_q || out_ready);
	assign q_pop      = q_not_empty && !clr_q && (!valid_s1 || adv);
	assign addr_s1    = cmd_s1.tbl_addr[AW-1:0];
	assign cnt_tbl_wr = adv && (cmd_s1.op == OP_CNT_TBL);

	assign ram_we    = clr_q || cnt_tbl_wr;
	assign ram_waddr = clr_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_q ? '0 : tbl_inc;

	phc_ram #(
		.WIDTH(CNT_W),
		.DEPTH(TBL_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (q_pop),
		.raddr(q_head.tbl_addr[AW-1:0]),
		.rdata(rdata)
	);

	assign tbl_val = (lw_valid_q && lw_addr_q == addr_s1) ? lw_data_q : rdata;
	assign tbl_inc = tbl_val + 1'b1;
	assign unk_val = unk_q[cmd_s1.unk_idx];
	assign unk_inc = unk_val + 1'b1;

	always_comb begin
		case (cmd_s1.op)
			OP_CNT_TBL: res = '{counter_value: tbl_inc, in_table: 1'b1};
			OP_CNT_UNK: res = '{counter_value: unk_inc, in_table: 1'b0};
			OP_RD_TBL:  res = '{counter_value: tbl_val, in_table: 1'b1};
			OP_RD_UNK:  res = '{counter_value: unk_val, in_table: 1'b0};
			default:    res = '{counter_value: '0, in_table: 1'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(TBL_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			lw_valid_q  <= 1'b0;
			for (int i = 0; i < UNK_N; i++) begin
				unk_q[i] <= '0;
			end
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cnt_tbl_wr) begin
				lw_valid_q <= 1'b1;
			end
			if (adv && cmd_s1.op == OP_CNT_UNK) begin
				unk_q[cmd_s1.unk_idx] <= unk_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1 <= q_head;
		end
		if (adv) begin
			out_q <= res;
		end
		if (cnt_tbl_wr) begin
			lw_addr_q <= addr_s1;
			lw_data_q <= tbl_inc;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`PHC_NEVER(a_no_pop_in_clear, clk, arst_n, clr_q && q_pop, "pop during clearing pass")
	`PHC_NEVER(a_no_count_in_clear, clk, arst_n, clr_q && cnt_tbl_wr, "count write during clear")
	`PHC_ASSERT(a_adv_loads_out, clk, arst_n, adv |=> out_valid_q, "result register not loaded")
	`PHC_ASSERT(a_s1_holds, clk, arst_n, (valid_s1 && !adv) |=> (valid_s1 && $stable(cmd_s1)), "stalled stage lost its command")

endmodule
`default_nettype wire
